// ===== hw/rtl/mdu_pkg.sv =====
// mdu_pkg: shared constants, opcodes and stage control type of the multiply/divide unit
// no dependencies; imported by the interfaces and all mdu modules
package mdu_pkg;

  localparam int DATA_BITS      = 32;
  localparam int OPCODE_BITS    = 2;
  localparam int DEF_WORD_BITS  = 32;

  localparam logic [OPCODE_BITS-1:0] OP_DIV  = 2'd0;
  localparam logic [OPCODE_BITS-1:0] OP_DIVU = 2'd1;
  localparam logic [OPCODE_BITS-1:0] OP_MUL  = 2'd2;
  localparam logic [OPCODE_BITS-1:0] OP_MULU = 2'd3;

  typedef struct packed {
    logic valid;
    logic is_div;
    logic neg_hi;
    logic neg_lo;
    logic dz;
  } ctl_t;

endpackage

// ===== hw/rtl/mdu_req_if.sv =====
// mdu_req_if: operation channel, opcode and two operands with valid/ready
// depends on mdu_pkg
interface mdu_req_if import mdu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OPCODE_BITS-1:0] opcode;
  logic [DATA_BITS-1:0]   operand_a;
  logic [DATA_BITS-1:0]   operand_b;

  modport source (output valid, output opcode, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input opcode, input operand_a, input operand_b,
                output ready);
endinterface

// ===== hw/rtl/mdu_rsp_if.sv =====
// mdu_rsp_if: result channel, hi/lo words and divide-by-zero flag with valid/ready
// depends on mdu_pkg
interface mdu_rsp_if import mdu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [DATA_BITS-1:0] hi_word;
  logic [DATA_BITS-1:0] lo_word;
  logic                 divide_by_zero;

  modport source (output valid, output hi_word, output lo_word, output divide_by_zero,
                  input ready);
  modport sink (input valid, input hi_word, input lo_word, input divide_by_zero,
                output ready);
endinterface

// ===== hw/rtl/multiply_divide_unit.sv =====
// multiply_divide_unit: pipelined hi/lo multiply and divide, signed and unsigned
// depends on mdu_pkg, mdu_req_if, mdu_rsp_if, mdu_prep, mdu_step, mdu_fix
//
//   port   direction  contents
//   req    sink       opcode, operand_a, operand_b
//   rsp    source     hi_word, lo_word, divide_by_zero
//
// one transfer per cycle in, one per cycle out, while the output is not stalled
// stages: prep stage, one bit step per stage, sign fix / output register
// every stage advances together when the output register is empty or taken
// a stall holds all stages, req.ready falls in the same cycle
// rst clears only the stage control words and the output valid bit
module multiply_divide_unit import mdu_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic      clk,
  input  logic      rst,
  mdu_req_if.sink   req,
  mdu_rsp_if.source rsp
);

  logic                 adv;
  ctl_t                 ctl [0:WORD_BITS];
  logic [WORD_BITS-1:0] hi  [0:WORD_BITS];
  logic [WORD_BITS-1:0] lo  [0:WORD_BITS];
  logic [WORD_BITS-1:0] m   [0:WORD_BITS];

  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  mdu_prep #(.WORD_BITS(WORD_BITS)) u_prep (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (req.valid),
    .opcode   (req.opcode),
    .a        (req.operand_a[WORD_BITS-1:0]),
    .b        (req.operand_b[WORD_BITS-1:0]),
    .ctl      (ctl[0]),
    .hi       (hi[0]),
    .lo       (lo[0]),
    .m        (m[0])
  );

  for (genvar k = 0; k < WORD_BITS; k++) begin : g_step
    mdu_step #(.WORD_BITS(WORD_BITS)) u_step (
      .clk    (clk),
      .rst    (rst),
      .en     (adv),
      .ctl_in (ctl[k]),
      .hi_in  (hi[k]),
      .lo_in  (lo[k]),
      .m_in   (m[k]),
      .ctl    (ctl[k+1]),
      .hi     (hi[k+1]),
      .lo     (lo[k+1]),
      .m      (m[k+1])
    );
  end

  mdu_fix #(.WORD_BITS(WORD_BITS)) u_fix (
    .clk            (clk),
    .rst            (rst),
    .en             (adv),
    .ctl_in         (ctl[WORD_BITS]),
    .hi_in          (hi[WORD_BITS]),
    .lo_in          (lo[WORD_BITS]),
    .valid          (rsp.valid),
    .hi_word        (rsp.hi_word),
    .lo_word        (rsp.lo_word),
    .divide_by_zero (rsp.divide_by_zero)
  );

  a_dz_quotient_ones: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.divide_by_zero |-> (&rsp.lo_word[WORD_BITS-1:0]))
    else $error("zero divisor result without all-ones quotient");

  a_dz_only_divide: assert property (@(posedge clk) disable iff (rst)
    ctl[WORD_BITS].valid && ctl[WORD_BITS].dz |-> ctl[WORD_BITS].is_div)
    else $error("zero divisor flag on a multiply");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(ctl[0].valid) && $stable(ctl[WORD_BITS].valid))
    else $error("pipeline moved during stall");

  a_dz_detect: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && (req.opcode == OP_DIV || req.opcode == OP_DIVU)
      && (req.operand_b[WORD_BITS-1:0] == '0) |=> ctl[0].dz)
    else $error("zero divisor not flagged");

endmodule

// ===== hw/rtl/mdu_prep.sv =====
// mdu_prep: first pipeline stage, operand magnitudes, sign bookkeeping and zero-divisor check
// depends on mdu_pkg
module mdu_prep import mdu_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [OPCODE_BITS-1:0] opcode,
  input  logic [WORD_BITS-1:0]   a,
  input  logic [WORD_BITS-1:0]   b,
  output ctl_t                   ctl,
  output logic [WORD_BITS-1:0]   hi,
  output logic [WORD_BITS-1:0]   lo,
  output logic [WORD_BITS-1:0]   m
);

  ctl_t                 ctl_next;
  logic [WORD_BITS-1:0] lo_next;
  logic [WORD_BITS-1:0] m_next;
  logic                 is_signed;
  logic                 sa;
  logic                 sb;
  logic [WORD_BITS-1:0] mag_a;
  logic [WORD_BITS-1:0] mag_b;

  always_comb begin
    is_signed       = (opcode == OP_DIV) || (opcode == OP_MUL);
    ctl_next.valid  = in_valid;
    ctl_next.is_div = (opcode == OP_DIV) || (opcode == OP_DIVU);
    sa              = is_signed & a[WORD_BITS-1];
    sb              = is_signed & b[WORD_BITS-1];
    mag_a           = sa ? (~a + 1'b1) : a;
    mag_b           = sb ? (~b + 1'b1) : b;
    ctl_next.dz     = ctl_next.is_div & (b == '0);
    // divide: remainder follows dividend, quotient left alone on zero divisor
    ctl_next.neg_hi = ctl_next.is_div ? sa : (sa ^ sb);
    ctl_next.neg_lo = (sa ^ sb) & ~ctl_next.dz;
    lo_next         = ctl_next.is_div ? mag_a : mag_b;
    m_next          = ctl_next.is_div ? mag_b : mag_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi <= '0;
      lo <= lo_next;
      m  <= m_next;
    end
  end

endmodule

// ===== hw/rtl/mdu_step.sv =====
// mdu_step: one bit step, shift-add for multiply or restoring subtract for divide
// depends on mdu_pkg
module mdu_step import mdu_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic [WORD_BITS-1:0] hi_in,
  input  logic [WORD_BITS-1:0] lo_in,
  input  logic [WORD_BITS-1:0] m_in,
  output ctl_t                 ctl,
  output logic [WORD_BITS-1:0] hi,
  output logic [WORD_BITS-1:0] lo,
  output logic [WORD_BITS-1:0] m
);

  logic [WORD_BITS:0]   sum;
  logic [WORD_BITS:0]   shifted;
  logic [WORD_BITS:0]   diff;
  logic                 ge;
  logic [WORD_BITS-1:0] hi_next;
  logic [WORD_BITS-1:0] lo_next;

  always_comb begin
    // multiply: add multiplicand on low bit, shift right
    sum     = {1'b0, hi_in} + (lo_in[0] ? {1'b0, m_in} : '0);
    // divide: shift in next dividend bit, trial subtract
    shifted = {hi_in, lo_in[WORD_BITS-1]};
    diff    = shifted - {1'b0, m_in};
    ge      = ~diff[WORD_BITS];
    if (ctl_in.is_div) begin
      hi_next = ge ? diff[WORD_BITS-1:0] : shifted[WORD_BITS-1:0];
      lo_next = {lo_in[WORD_BITS-2:0], ge};
    end else begin
      hi_next = sum[WORD_BITS:1];
      lo_next = {sum[0], lo_in[WORD_BITS-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi <= hi_next;
      lo <= lo_next;
      m  <= m_in;
    end
  end

endmodule

// ===== hw/rtl/mdu_fix.sv =====
// mdu_fix: last stage, sign correction of product, quotient and remainder into the output register
// depends on mdu_pkg
module mdu_fix import mdu_pkg::*; #(
  parameter int WORD_BITS = DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  ctl_t                 ctl_in,
  input  logic [WORD_BITS-1:0] hi_in,
  input  logic [WORD_BITS-1:0] lo_in,
  output logic                 valid,
  output logic [DATA_BITS-1:0] hi_word,
  output logic [DATA_BITS-1:0] lo_word,
  output logic                 divide_by_zero
);

  logic [2*WORD_BITS-1:0] prod;
  logic [WORD_BITS-1:0]   quo;
  logic [WORD_BITS-1:0]   rem;
  logic [DATA_BITS-1:0]   hi_next;
  logic [DATA_BITS-1:0]   lo_next;

  always_comb begin
    prod = ctl_in.neg_lo ? (~{hi_in, lo_in} + 1'b1) : {hi_in, lo_in};
    rem  = ctl_in.neg_hi ? (~hi_in + 1'b1) : hi_in;
    if (ctl_in.dz) begin
      quo = '1;
    end else begin
      quo = ctl_in.neg_lo ? (~lo_in + 1'b1) : lo_in;
    end
    hi_next = '0;
    lo_next = '0;
    if (ctl_in.is_div) begin
      hi_next[WORD_BITS-1:0] = rem;
      lo_next[WORD_BITS-1:0] = quo;
    end else begin
      hi_next[WORD_BITS-1:0] = prod[2*WORD_BITS-1:WORD_BITS];
      lo_next[WORD_BITS-1:0] = prod[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_word        <= hi_next;
      lo_word        <= lo_next;
      divide_by_zero <= ctl_in.dz;
    end
  end

endmodule

// ===== tb/sv/tb_multiply_divide_unit.sv =====
`timescale 1ns / 100ps
// tb_multiply_divide_unit: self-checking testbench for the hi/lo multiply/divide unit
// depends on mdu_pkg, mdu_req_if, mdu_rsp_if and multiply_divide_unit
// directed table of edge cases, then random operations checked against a local predictor
module tb_multiply_divide_unit;
  import mdu_pkg::*;

  localparam int ITEM_COUNT   = 1300;
  localparam int PAUSE_AT     = 700;
  localparam int STEADY_FROM  = ITEM_COUNT - 200;
  localparam int LONG_HOLD    = 150;
  localparam int HOLD_AFTER   = 250;
  localparam int DRAIN_CYCLES = DEF_WORD_BITS + 10;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_LIMIT  = 30;

  typedef logic [DATA_BITS-1:0] word_t;

  typedef struct packed {
    word_t hi;
    word_t lo;
    logic  dz;
  } hilo_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    word_t                  a;
    word_t                  b;
    hilo_t                  want;
  } op_record_t;

  typedef struct packed {
    logic [OPCODE_BITS-1:0] opcode;
    word_t                  a;
    word_t                  b;
    bit                     known;
    word_t                  hi;
    word_t                  lo;
    logic                   dz;
  } table_row_t;

  localparam int NUM_DIRECTED = 24;

  table_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_DIV,  32'h0000_0007, 32'h0000_0000, 1'b1, 32'h0000_0007, 32'hFFFF_FFFF, 1'b1},
    '{OP_DIVU, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1},
    '{OP_DIV,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1},
    '{OP_DIV,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1},
    '{OP_DIV,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0},
    '{OP_DIV,  32'h8000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h8000_0000, 1'b0},
    '{OP_DIV,  32'hFFFF_FFF9, 32'h0000_0002, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFD, 1'b0},
    '{OP_DIV,  32'h0000_0007, 32'hFFFF_FFFE, 1'b1, 32'h0000_0001, 32'hFFFF_FFFD, 1'b0},
    '{OP_DIV,  32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b1, 32'hFFFF_FFFF, 32'h0000_0003, 1'b0},
    '{OP_DIVU, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
    '{OP_DIVU, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000, 32'h0000_0000, 1'b0},
    '{OP_MULU, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFE, 32'h0000_0001, 1'b0},
    '{OP_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0001, 1'b0},
    '{OP_MUL,  32'h8000_0000, 32'h8000_0000, 1'b1, 32'h4000_0000, 32'h0000_0000, 1'b0},
    '{OP_MULU, 32'h8000_0000, 32'h0000_0002, 1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
    '{OP_MUL,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{OP_MULU, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
    '{OP_MUL,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_MUL,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_MUL,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_MULU, 32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_DIVU, 32'h1234_5678, 32'h0000_9ABC, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_DIV,  32'h0000_0001, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_DIV,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  mdu_req_if req_ch ();
  mdu_rsp_if rsp_ch ();

  multiply_divide_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  op_record_t awaited_hilo [$];
  int         mismatch_count = 0;
  int         results_seen   = 0;
  int         zero_div_seen  = 0;
  int         cycle_count    = 0;
  int         op_sent [4]    = '{0, 0, 0, 0};
  bit         steady_phase   = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic hilo_t compute_hilo(input logic [OPCODE_BITS-1:0] opcode,
                                         input word_t a, input word_t b);
    hilo_t       r;
    int          a_int;
    int          b_int;
    longint      sa;
    longint      sb;
    longint      sq;
    longint      sr;
    logic [63:0] prod;
    r = '0;
    a_int = a;
    b_int = b;
    sa = longint'(a_int);
    sb = longint'(b_int);
    case (opcode)
      OP_MUL: begin
        prod = sa * sb;
        r.hi = prod[63:32];
        r.lo = prod[31:0];
      end
      OP_MULU: begin
        prod = {32'b0, a} * {32'b0, b};
        r.hi = prod[63:32];
        r.lo = prod[31:0];
      end
      default: begin
        if (b == '0) begin
          r.dz = 1'b1;
          r.lo = '1;
          r.hi = a;
        end else if (opcode == OP_DIV) begin
          sq = sa / sb;
          sr = sa % sb;
          r.lo = sq[31:0];
          r.hi = sr[31:0];
        end else begin
          r.lo = a / b;
          r.hi = a % b;
        end
      end
    endcase
    return r;
  endfunction

  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = 32'h0000_0001;
      2: v = '1;
      3: v = 32'h8000_0000;
      4: v = 32'h7FFF_FFFF;
      5: v = $urandom_range(0, 255);
      6: v = -$urandom_range(1, 255);
      7: v = $urandom >> $urandom_range(1, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // timeout
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off
  initial begin : result_sink
    int stall_left;
    int stall_rate;
    int window;
    bit long_hold_done;
    stall_left = 0;
    stall_rate = 0;
    window = 0;
    long_hold_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (window % 64 == 0) stall_rate = $urandom_range(0, 3);
      window++;
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !steady_phase && stall_rate != 0 &&
                   $urandom_range(0, 7) < stall_rate) begin
        stall_left = $urandom_range(1, 4);
      end
      if (stall_left > 0) begin
        rsp_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    op_record_t rec;
    if (rst === 1'b0 && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (rsp_ch.divide_by_zero) zero_div_seen++;
      if (awaited_hilo.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
          $display("%0t: result with none expected: hi=%h lo=%h dz=%b", $time,
                   rsp_ch.hi_word, rsp_ch.lo_word, rsp_ch.divide_by_zero);
      end else begin
        rec = awaited_hilo.pop_front();
        if (rsp_ch.hi_word !== rec.want.hi) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: op %0d a=%h b=%h hi_word expected %h actual %h", $time,
                     rec.opcode, rec.a, rec.b, rec.want.hi, rsp_ch.hi_word);
        end
        if (rsp_ch.lo_word !== rec.want.lo) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: op %0d a=%h b=%h lo_word expected %h actual %h", $time,
                     rec.opcode, rec.a, rec.b, rec.want.lo, rsp_ch.lo_word);
        end
        if (rsp_ch.divide_by_zero !== rec.want.dz) begin
          mismatch_count++;
          if (mismatch_count <= PRINT_LIMIT)
            $display("%0t: op %0d a=%h b=%h divide_by_zero expected %b actual %b", $time,
                     rec.opcode, rec.a, rec.b, rec.want.dz, rsp_ch.divide_by_zero);
        end
      end
    end
  end

  // operation side: directed table, then random operations
  initial begin : op_source
    op_record_t rec;
    int         gap_rate;
    rst = 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.opcode    <= OP_DIV;
    req_ch.operand_a <= '0;
    req_ch.operand_b <= '0;
    gap_rate = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < ITEM_COUNT; i++) begin
      if (i < NUM_DIRECTED) begin
        rec.opcode = directed_rows[i].opcode;
        rec.a      = directed_rows[i].a;
        rec.b      = directed_rows[i].b;
        if (directed_rows[i].known)
          rec.want = '{directed_rows[i].hi, directed_rows[i].lo, directed_rows[i].dz};
        else
          rec.want = compute_hilo(rec.opcode, rec.a, rec.b);
      end else begin
        rec.opcode = OPCODE_BITS'($urandom_range(0, 3));
        rec.a      = pick_operand();
        rec.b      = pick_operand();
        rec.want   = compute_hilo(rec.opcode, rec.a, rec.b);
      end
      if (i % 50 == 0) gap_rate = $urandom_range(0, 3);
      steady_phase = (i >= STEADY_FROM);
      if (i == PAUSE_AT) begin
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_hilo.size() != 0);
      end else if (!steady_phase && gap_rate != 0 && $urandom_range(0, 7) < gap_rate) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      req_ch.valid     <= 1'b1;
      req_ch.opcode    <= rec.opcode;
      req_ch.operand_a <= rec.a;
      req_ch.operand_b <= rec.b;
      do @(posedge clk); while (!req_ch.ready);
      awaited_hilo.push_back(rec);
      op_sent[rec.opcode]++;
    end
    req_ch.valid <= 1'b0;
    while (awaited_hilo.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d operations (%0d directed): div %0d, divu %0d, mul %0d, mulu %0d",
             ITEM_COUNT, NUM_DIRECTED, op_sent[OP_DIV], op_sent[OP_DIVU],
             op_sent[OP_MUL], op_sent[OP_MULU]);
    $display("%0d results compared, %0d with zero divisor, %0d mismatches",
             results_seen, zero_div_seen, mismatch_count);
    if (mismatch_count == 0 && awaited_hilo.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mdu_pkg.sv
hw/rtl/mdu_req_if.sv
hw/rtl/mdu_rsp_if.sv
hw/rtl/mdu_prep.sv
hw/rtl/mdu_step.sv
hw/rtl/mdu_fix.sv
hw/rtl/multiply_divide_unit.sv
tb/sv/tb_multiply_divide_unit.sv
